/* design/lpfr_pkg.sv */
`default_nettype none
package lpfr_pkg;

  localparam int FRAME_MAX_DEF = 35;

  // header & LEN_MASK, plus LEN_EXTRA, gives the frame length in bytes
  localparam logic [7:0] LEN_MASK  = 8'h7f;
  localparam logic [7:0] LEN_EXTRA = 8'd3;
  localparam logic [5:0] LEN_MIN   = 6'd4;

  localparam logic [5:0] MAX_LEN_RST = 6'd35;
  localparam logic [7:0] TIMEOUT_RST = 8'd100;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  localparam logic [7:0] GAP_SAT = 8'hff;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN     = 2'd1,
    ST_SUM     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef struct packed {
    logic [5:0] max_len;
    logic [7:0] timeout;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

/* design/length_prefixed_frame_receiver.sv */
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  in_operation, in_rx_byte
// out      source     out_valid/out_stall  out_status, out_data, out_index, out_last
// cfg      sink       cfg_wr_en            cfg_index, cfg_wdata
//
// One event a cycle when not stalled; items pass the input and result registers.
// The frame state update is one pass of compare/add logic between the input
// register and the result register: one item per cycle unless stalled.
// Synchronous active-low reset returns the receiver to idle with the
// configuration at its defaults; no clearing pass is needed.
// in_stall rises only while the result register is full and out_stall is high.
`default_nettype none
module length_prefixed_frame_receiver #(
  parameter int FRAME_MAX = lpfr_pkg::FRAME_MAX_DEF,
  parameter int IDX_W     = $clog2(FRAME_MAX)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_operation,
  input  wire logic [7:0]                      in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_status,
  output logic [7:0]                           out_data,
  output logic [IDX_W-1:0]                     out_index,
  output logic                                 out_last,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lpfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpfr_pkg::*;

  cfg_t             cfg;
  logic             s1_valid_r;
  logic             s1_tick_r;
  logic [7:0]       s1_byte_r;
  logic             advance;
  logic             proc;
  logic             res_valid;
  res_t             res;
  logic [IDX_W-1:0] res_index;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [7:0]       out_data_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_last_r;

  lpfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage 1 moves on whenever the result slot is free or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign proc     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick_r <= in_operation;
      s1_byte_r <= in_rx_byte;
    end
  end

  lpfr_frame_fsm #(
    .FRAME_MAX (FRAME_MAX),
    .IDX_W     (IDX_W)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (proc),
    .item_tick  (s1_tick_r),
    .item_byte  (s1_byte_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_index  (res_index)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && proc && res_valid) begin
      out_status_r <= res.status;
      out_data_r   <= res.data;
      out_index_r  <= res_index;
      out_last_r   <= res.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_index  = out_index_r;
  assign out_last   = out_last_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled without a blocked result");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_tick_r)))
    else $error("stage 1 item lost during stall");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !proc) |=> !out_valid_r)
    else $error("result appeared without a processed item");

endmodule
`default_nettype wire

/* design/lpfr_cfg_regs.sv */
`default_nettype none
module lpfr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lpfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lpfr_pkg::cfg_t                      cfg
);
  import lpfr_pkg::*;

  logic [5:0] max_len_r;
  logic [7:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_FRAME_LEN: max_len_r <= cfg_wdata[5:0];
        CFG_TIMEOUT_TICKS: timeout_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.max_len = max_len_r;
  assign cfg.timeout = timeout_r;

endmodule
`default_nettype wire

/* design/lpfr_frame_fsm.sv */
`default_nettype none
module lpfr_frame_fsm #(
  parameter int FRAME_MAX = lpfr_pkg::FRAME_MAX_DEF,
  parameter int IDX_W     = $clog2(FRAME_MAX)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  lpfr_pkg::cfg_t        cfg,
  input  wire logic             item_valid,
  input  wire logic             item_tick,
  input  wire logic [7:0]       item_byte,
  output logic                  res_valid,
  output lpfr_pkg::res_t        res,
  output logic [IDX_W-1:0]      res_index
);
  import lpfr_pkg::*;

  localparam int         CNT_W       = $clog2(FRAME_MAX + 1);
  localparam logic [7:0] FRAME_MAX_B = 8'(FRAME_MAX);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DRAIN   = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] frame_len_r, frame_len_nxt;
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       gap_r, gap_nxt;

  logic [7:0]       hdr_len;
  logic             len_bad;
  logic [7:0]       gap_inc;
  logic             timed_out;
  logic [7:0]       sum_add;
  logic [CNT_W-1:0] cnt_inc;
  logic             at_last;

  always_comb begin
    hdr_len   = (item_byte & LEN_MASK) + LEN_EXTRA;
    len_bad   = (cfg.max_len < LEN_MIN) || (hdr_len > {2'b00, cfg.max_len}) ||
                (hdr_len > FRAME_MAX_B);
    gap_inc   = (gap_r == GAP_SAT) ? gap_r : gap_r + 8'd1;
    timed_out = gap_inc >= cfg.timeout;
    sum_add   = sum_r + item_byte;
    cnt_inc   = byte_cnt_r + CNT_W'(1);
    at_last   = cnt_inc >= frame_len_r;
  end

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    byte_cnt_nxt  = byte_cnt_r;
    sum_nxt       = sum_r;
    gap_nxt       = gap_r;
    res_valid     = 1'b0;
    res.status    = ST_OK;
    res.data      = item_byte;
    res.last      = 1'b0;
    res_index     = '0;
    if (item_valid) begin
      case (phase_r)
        PH_COLLECT: begin
          if (item_tick) begin
            gap_nxt = gap_inc;
            if (timed_out) begin
              phase_nxt  = PH_DRAIN;
              gap_nxt    = '0;
              res_valid  = 1'b1;
              res.status = ST_TIMEOUT;
              res.data   = '0;
            end
          end else begin
            gap_nxt      = '0;
            sum_nxt      = sum_add;
            byte_cnt_nxt = cnt_inc;
            res_valid    = 1'b1;
            res_index    = byte_cnt_r[IDX_W-1:0];
            res.last     = at_last;
            if (at_last) begin
              if (sum_add == 8'd0) begin
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt  = PH_DRAIN;
                res.status = ST_SUM;
              end
            end
          end
        end
        PH_DRAIN: begin
          if (item_tick) begin
            gap_nxt = gap_inc;
            if (timed_out) begin
              phase_nxt = PH_IDLE;
              gap_nxt   = '0;
            end
          end else begin
            gap_nxt = '0;
            if (item_byte == 8'd0) phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (!item_tick) begin
            gap_nxt   = '0;
            res_valid = 1'b1;
            if (len_bad) begin
              phase_nxt  = PH_DRAIN;
              res.status = ST_LEN;
            end else begin
              // header always fits CNT_W once it passes the FRAME_MAX check
              frame_len_nxt = hdr_len[CNT_W-1:0];
              byte_cnt_nxt  = CNT_W'(1);
              sum_nxt       = item_byte;
              phase_nxt     = PH_COLLECT;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_len_r <= '0;
      byte_cnt_r  <= '0;
      sum_r       <= '0;
      gap_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      sum_r       <= sum_nxt;
      gap_r       <= gap_nxt;
    end
  end

  a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && phase_r == PH_DRAIN) |-> !res_valid)
    else $error("result produced while draining");

  a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COLLECT) |-> (byte_cnt_r < frame_len_r))
    else $error("byte count reached frame length while collecting");

  a_sum_err_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_SUM) |=> (phase_r == PH_DRAIN))
    else $error("checksum error did not enter drain");

  a_good_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last && res.status == ST_OK) |=> (phase_r == PH_IDLE))
    else $error("good frame end did not return to idle");

endmodule
`default_nettype wire
